### rtl/core/hpnl_pkg.sv
// shared types, constants and offset sets for the hex pad neighbor list unit
`default_nettype none

package hpnl_pkg;

  localparam int unsigned PadW          = 11;
  localparam int unsigned OffW          = 8;
  localparam int unsigned MaxNbr        = 8;
  localparam int unsigned PAD_COUNT_DEF = 1400;

  // offset set selector
  typedef enum logic [3:0] {
    SET_BAND_A,
    SET_BAND_B,
    SET_BAND_C,
    SET_BAND_D,
    SET_BAND_E,
    SET_BAND_F,
    SET_BAND_G,
    SET_BAND_H,
    SET_EDGE,
    SET_STAG_L,
    SET_STAG_R,
    SET_NONE
  } set_sel_e;

  typedef struct packed {
    logic [3:0]                 count;
    logic [0:MaxNbr-1][OffW-1:0] off;
  } offset_set_t;

  // candidate neighbors of one pad, passed to the emitter
  typedef struct packed {
    logic [MaxNbr-1:0][PadW-1:0] pad;
    logic [MaxNbr-1:0]           keep;
  } nbr_set_t;

  localparam offset_set_t OFFSET_SETS [12] = '{
    // 640, 679, 680
    '{4'd5, '{-8'sd40, -8'sd20, 8'sd20, 8'sd40, 8'sd60, 8'sd0, 8'sd0, 8'sd0}},
    // 641..659
    '{4'd7, '{-8'sd40, -8'sd21, -8'sd20, 8'sd19, 8'sd20, 8'sd40, 8'sd60, 8'sd0}},
    // 660..678
    '{4'd8, '{-8'sd40, -8'sd20, -8'sd19, 8'sd20, 8'sd21, 8'sd40, 8'sd41, 8'sd60}},
    // 681..699
    '{4'd7, '{-8'sd40, -8'sd21, -8'sd20, 8'sd20, 8'sd39, 8'sd40, 8'sd60, 8'sd0}},
    // 700, 739, 740
    '{4'd5, '{-8'sd60, -8'sd40, -8'sd20, 8'sd20, 8'sd40, 8'sd0, 8'sd0, 8'sd0}},
    // 701..719
    '{4'd7, '{-8'sd60, -8'sd41, -8'sd40, -8'sd20, 8'sd19, 8'sd20, 8'sd40, 8'sd0}},
    // 720..738
    '{4'd8, '{-8'sd60, -8'sd40, -8'sd39, -8'sd20, -8'sd19, 8'sd20, 8'sd21, 8'sd40}},
    // 741..759
    '{4'd7, '{-8'sd60, -8'sd40, -8'sd21, -8'sd20, 8'sd19, 8'sd20, 8'sd40, 8'sd0}},
    // edge pads
    '{4'd4, '{-8'sd40, -8'sd20, 8'sd20, 8'sd40, 8'sd0, 8'sd0, 8'sd0, 8'sd0}},
    // stagger, left lean
    '{4'd6, '{-8'sd40, -8'sd21, -8'sd20, 8'sd19, 8'sd20, 8'sd40, 8'sd0, 8'sd0}},
    // stagger, right lean
    '{4'd6, '{-8'sd40, -8'sd20, -8'sd19, 8'sd20, 8'sd21, 8'sd40, 8'sd0, 8'sd0}},
    // no neighbors
    '{4'd0, '{8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0}}
  };

endpackage

`default_nettype wire

### rtl/core/hpnl_offsets.sv
// offset set selection and candidate neighbor sums for one pad
`default_nettype none

module hpnl_offsets #(
  parameter int unsigned PAD_COUNT = hpnl_pkg::PAD_COUNT_DEF
) (
  input  wire logic [hpnl_pkg::PadW-1:0] pad_i,
  output hpnl_pkg::nbr_set_t             nbr_o
);
  import hpnl_pkg::*;

  localparam int unsigned SumW = PadW + 2;

  logic [PadW+12-1:0] row_prod;
  logic [PadW-1:0]    row;
  logic [PadW-1:0]    row40;
  logic [5:0]         mod40;
  logic               odd_row;
  set_sel_e           sel;
  offset_set_t        oset;
  logic [SumW-1:0]    sum [MaxNbr];

  // row = pad / 20 by reciprocal multiply, exact for 11-bit pads
  assign row_prod = {12'd0, pad_i} * (PadW+12)'(3277);
  assign row      = {4'd0, row_prod[PadW+12-1:16]};
  assign odd_row  = row[0];
  assign row40    = PadW'({1'b0, row[PadW-1:1]} * PadW'(40));
  assign mod40    = 6'(pad_i - row40);

  // pick the offset set, border band first
  always_comb begin
    priority if (pad_i == 11'd640) begin
      sel = SET_BAND_A;
    end else if (pad_i >= 11'd641 && pad_i <= 11'd659) begin
      sel = SET_BAND_B;
    end else if (pad_i >= 11'd660 && pad_i <= 11'd678) begin
      sel = SET_BAND_C;
    end else if (pad_i == 11'd679 || pad_i == 11'd680) begin
      sel = SET_BAND_A;
    end else if (pad_i >= 11'd681 && pad_i <= 11'd699) begin
      sel = SET_BAND_D;
    end else if (pad_i == 11'd700) begin
      sel = SET_BAND_E;
    end else if (pad_i >= 11'd701 && pad_i <= 11'd719) begin
      sel = SET_BAND_F;
    end else if (pad_i >= 11'd720 && pad_i <= 11'd738) begin
      sel = SET_BAND_G;
    end else if (pad_i == 11'd739 || pad_i == 11'd740) begin
      sel = SET_BAND_E;
    end else if (pad_i >= 11'd741 && pad_i <= 11'd759) begin
      sel = SET_BAND_H;
    end else if (pad_i <= 11'd699) begin
      if (mod40 == 6'd0 || mod40 == 6'd39) begin
        sel = SET_EDGE;
      end else begin
        sel = odd_row ? SET_STAG_R : SET_STAG_L;
      end
    end else if (pad_i <= 11'd1399) begin
      if (mod40 == 6'd20 || mod40 == 6'd19) begin
        sel = SET_EDGE;
      end else begin
        sel = odd_row ? SET_STAG_L : SET_STAG_R;
      end
    end else begin
      sel = SET_NONE;
    end
  end

  assign oset = OFFSET_SETS[sel];

  // add each offset and keep sums inside the pad range
  always_comb begin
    for (int i = 0; i < MaxNbr; i++) begin
      sum[i] = {2'b00, pad_i} + {{(SumW-OffW){oset.off[i][OffW-1]}}, oset.off[i]};
      nbr_o.pad[i]  = sum[i][PadW-1:0];
      nbr_o.keep[i] = (4'(i) < oset.count) && !sum[i][SumW-1]
                      && (sum[i][SumW-2:0] < (SumW-1)'(PAD_COUNT));
    end
  end

endmodule

`default_nettype wire

### rtl/core/hpnl_emit.sv
// result stage: sends the kept neighbors of one pad, one per cycle, or one empty result if none is kept
`default_nettype none

module hpnl_emit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      load_i,
  input  hpnl_pkg::nbr_set_t             nbr_i,
  output logic                           free_o,
  output logic                           valid_o,
  output logic [hpnl_pkg::PadW-1:0]      neighbor_pad_o,
  output logic                           found_o,
  output logic                           last_o
);
  import hpnl_pkg::*;

  logic                        valid_q, valid_d;
  logic [MaxNbr-1:0]           keep_q, keep_d;
  logic [MaxNbr-1:0][PadW-1:0] pad_q;
  logic [MaxNbr-1:0]           rest;
  logic [PadW-1:0]             pick;

  // lowest kept candidate goes out first
  always_comb begin
    pick = '0;
    for (int i = MaxNbr-1; i >= 0; i--) begin
      if (keep_q[i]) begin
        pick = pad_q[i];
      end
    end
  end

  assign rest           = keep_q & (keep_q - MaxNbr'(1));
  assign valid_o        = valid_q;
  assign found_o        = |keep_q;
  assign neighbor_pad_o = found_o ? pick : '0;
  assign last_o         = (rest == '0);
  assign free_o         = !valid_q || last_o;

  // next state of the result stage
  always_comb begin
    valid_d = valid_q;
    keep_d  = keep_q;
    if (load_i) begin
      valid_d = 1'b1;
      keep_d  = nbr_i.keep;
    end else if (valid_q) begin
      valid_d = !last_o;
      keep_d  = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      keep_q  <= '0;
    end else begin
      valid_q <= valid_d;
      keep_q  <= keep_d;
    end
  end

  // candidate sums, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pad_q <= nbr_i.pad;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hex_pad_neighbor_list_unit.sv
// top level of the hex pad neighbor list unit
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  request  | start_i / busy_o      | pad_index_i
//  result   | valid_o (strobe)      | neighbor_pad_o, found_o, last_o
//
// a pad is registered on accept, its candidate sums are formed in the next
// cycle and the result stage then sends one neighbor per cycle (1 to 8
// results). the result stage sets the rate: a pad moves into it while the
// last result of the previous pad is out; a new pad is accepted while the
// input register is empty or moving on. reset is asynchronous and clears
// the pending, valid and keep flags only. the receiver cannot stall.
`default_nettype none

module hex_pad_neighbor_list_unit #(
  parameter int unsigned PAD_COUNT = hpnl_pkg::PAD_COUNT_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic [hpnl_pkg::PadW-1:0] pad_index_i,
  output logic                           valid_o,
  output logic [hpnl_pkg::PadW-1:0]      neighbor_pad_o,
  output logic                           found_o,
  output logic                           last_o
);
  import hpnl_pkg::*;

  logic            pend_q, pend_d;
  logic [PadW-1:0] pad_q;
  logic            accept;
  logic            advance;
  logic            emit_free;
  nbr_set_t        nbr;

  // input register moves on when the result stage frees up
  assign advance = pend_q && emit_free;
  assign busy_o  = pend_q && !emit_free;
  assign accept  = start_i && !busy_o;

  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = 1'b1;
    end else if (advance) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // accepted pad index
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pad_q <= pad_index_i;
    end
  end

  // candidate neighbors of the registered pad
  hpnl_offsets #(
    .PAD_COUNT (PAD_COUNT)
  ) u_offsets (
    .pad_i (pad_q),
    .nbr_o (nbr)
  );

  // one neighbor per cycle out
  hpnl_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (advance),
    .nbr_i          (nbr),
    .free_o         (emit_free),
    .valid_o        (valid_o),
    .neighbor_pad_o (neighbor_pad_o),
    .found_o        (found_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking testbench for the hex pad neighbor list unit
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hpnl_pkg::*;

  localparam int unsigned PadLimit    = 1400;
  localparam int unsigned NumRandom   = 450;
  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxShown    = 10;

  typedef struct {
    int cnt;
    int off[8];
  } offset_list_t;

  typedef struct packed {
    logic [PadW-1:0] pad;
    logic            found;
    logic            last;
  } nbr_result_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start_i     = 1'b0;
  logic [PadW-1:0] pad_index_i = '0;
  logic            busy_o;
  logic            valid_o;
  logic [PadW-1:0] neighbor_pad_o;
  logic            found_o;
  logic            last_o;

  logic [PadW-1:0] pending_pads[$];
  nbr_result_t     expected_nbrs[$];
  nbr_result_t     want;
  int unsigned     gap_left    = 0;
  int unsigned     burst_left  = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     error_count = 0;
  bit              hold_item;

  hex_pad_neighbor_list_unit #(
    .PAD_COUNT(PadLimit)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .pad_index_i   (pad_index_i),
    .valid_o       (valid_o),
    .neighbor_pad_o(neighbor_pad_o),
    .found_o       (found_o),
    .last_o        (last_o)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // offset set chosen by pad position
  function automatic set_sel_e select_set(int p);
    int m;
    bit odd_row;
    m       = p % 40;
    odd_row = ((p / 20) % 2) == 1;
    if (p == 640 || p == 679 || p == 680) return SET_BAND_A;
    if (p >= 641 && p <= 659) return SET_BAND_B;
    if (p >= 660 && p <= 678) return SET_BAND_C;
    if (p >= 681 && p <= 699) return SET_BAND_D;
    if (p == 700 || p == 739 || p == 740) return SET_BAND_E;
    if (p >= 701 && p <= 719) return SET_BAND_F;
    if (p >= 720 && p <= 738) return SET_BAND_G;
    if (p >= 741 && p <= 759) return SET_BAND_H;
    if (p <= 699) begin
      if (m == 0 || m == 39) return SET_EDGE;
      return odd_row ? SET_STAG_R : SET_STAG_L;
    end
    if (p <= 1399) begin
      if (m == 20 || m == 19) return SET_EDGE;
      return odd_row ? SET_STAG_L : SET_STAG_R;
    end
    return SET_NONE;
  endfunction

  // index offsets of each set, in emit order
  function automatic offset_list_t offsets_of(set_sel_e sel);
    offset_list_t r;
    case (sel)
      SET_BAND_A: begin
        r.cnt = 5; r.off = '{-40, -20, 20, 40, 60, 0, 0, 0};
      end
      SET_BAND_B: begin
        r.cnt = 7; r.off = '{-40, -21, -20, 19, 20, 40, 60, 0};
      end
      SET_BAND_C: begin
        r.cnt = 8; r.off = '{-40, -20, -19, 20, 21, 40, 41, 60};
      end
      SET_BAND_D: begin
        r.cnt = 7; r.off = '{-40, -21, -20, 20, 39, 40, 60, 0};
      end
      SET_BAND_E: begin
        r.cnt = 5; r.off = '{-60, -40, -20, 20, 40, 0, 0, 0};
      end
      SET_BAND_F: begin
        r.cnt = 7; r.off = '{-60, -41, -40, -20, 19, 20, 40, 0};
      end
      SET_BAND_G: begin
        r.cnt = 8; r.off = '{-60, -40, -39, -20, -19, 20, 21, 40};
      end
      SET_BAND_H: begin
        r.cnt = 7; r.off = '{-60, -40, -21, -20, 19, 20, 40, 0};
      end
      SET_EDGE: begin
        r.cnt = 4; r.off = '{-40, -20, 20, 40, 0, 0, 0, 0};
      end
      SET_STAG_L: begin
        r.cnt = 6; r.off = '{-40, -21, -20, 19, 20, 40, 0, 0};
      end
      SET_STAG_R: begin
        r.cnt = 6; r.off = '{-40, -20, -19, 20, 21, 40, 0, 0};
      end
      default: begin
        r.cnt = 0; r.off = '{0, 0, 0, 0, 0, 0, 0, 0};
      end
    endcase
    return r;
  endfunction

  // queue the neighbor list expected for one accepted pad
  task automatic predict_neighbors(input logic [PadW-1:0] pad);
    offset_list_t ol;
    nbr_result_t  r;
    int           q;
    int           i;
    int           last_i;
    ol     = offsets_of(select_set(int'(pad)));
    last_i = -1;
    for (i = 0; i < ol.cnt; i++) begin
      q = int'(pad) + ol.off[i];
      if (q >= 0 && q < int'(PadLimit)) last_i = i;
    end
    if (last_i < 0) begin
      // nothing in range: a single empty, final result
      r.pad   = '0;
      r.found = 1'b0;
      r.last  = 1'b1;
      expected_nbrs = {expected_nbrs, r};
    end else begin
      for (i = 0; i <= last_i; i++) begin
        q = int'(pad) + ol.off[i];
        if (q >= 0 && q < int'(PadLimit)) begin
          r.pad   = q[PadW-1:0];
          r.found = 1'b1;
          r.last  = (i == last_i);
          expected_nbrs = {expected_nbrs, r};
        end
      end
    end
  endtask

  // random pad, weighted toward the array, the border band, the row edges and pads past the end
  function automatic logic [PadW-1:0] random_pad();
    int unsigned r;
    int unsigned col;
    r = $urandom_range(99);
    if (r < 50) return PadW'($urandom_range(1399));
    if (r < 72) return PadW'($urandom_range(780, 620));
    if (r < 82) return PadW'($urandom_range(2047, 1400));
    if (r < 92) begin
      case ($urandom_range(3))
        0:       col = 0;
        1:       col = 19;
        2:       col = 20;
        default: col = 39;
      endcase
      return PadW'(40 * $urandom_range(34) + col);
    end
    return PadW'($urandom());
  endfunction

  // gap before the next request: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i     <= 1'b0;
      pad_index_i <= '0;
    end else begin
      hold_item = start_i && busy_o;
      if (start_i && !busy_o) begin
        predict_neighbors(pad_index_i);
        void'(pending_pads.pop_front());
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else begin
          gap_left = pick_gap();
          if ($urandom_range(19) == 0) burst_left = $urandom_range(40, 10);
        end
      end
      if (!hold_item) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i     <= 1'b0;
          pad_index_i <= PadW'($urandom());
        end else if (pending_pads.size() > 0) begin
          start_i     <= 1'b1;
          pad_index_i <= pending_pads[0];
        end else begin
          start_i     <= 1'b0;
          pad_index_i <= PadW'($urandom());
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_nbrs.size() == 0) begin
        error_count++;
        if (error_count <= MaxShown) begin
          $display("unexpected result: pad=%0d found=%0b last=%0b",
                   neighbor_pad_o, found_o, last_o);
        end
      end else begin
        want = expected_nbrs.pop_front();
        if (neighbor_pad_o !== want.pad || found_o !== want.found
            || last_o !== want.last) begin
          error_count++;
          if (error_count <= MaxShown) begin
            $display("mismatch: expected pad=%0d found=%0b last=%0b,",
                     want.pad, want.found, want.last,
                     " got pad=%0d found=%0b last=%0b",
                     neighbor_pad_o, found_o, last_o);
          end
        end
      end
    end
  end

  // cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // watchdog
  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("testbench: FAIL");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int unsigned n;
    logic [PadW-1:0] directed_pads[$];
    directed_pads = '{11'd0, 11'd19, 11'd20, 11'd39, 11'd639, 11'd640, 11'd641, 11'd660,
                      11'd679, 11'd680, 11'd681, 11'd699, 11'd700, 11'd701, 11'd719,
                      11'd720, 11'd739, 11'd740, 11'd759, 11'd760, 11'd1379, 11'd1380,
                      11'd1399, 11'd1400, 11'd2047};
    foreach (directed_pads[k]) pending_pads = {pending_pads, directed_pads[k]};
    for (n = 0; n < NumRandom; n++) pending_pads = {pending_pads, random_pad()};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_pads.size() != 0 || start_i) @(posedge clk_i);
    while (expected_nbrs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0 && expected_nbrs.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### hex_pad_neighbor_list_unit.f
rtl/core/hpnl_pkg.sv
rtl/core/hpnl_offsets.sv
rtl/core/hpnl_emit.sv
rtl/core/hex_pad_neighbor_list_unit.sv
tb/testbench.sv
